// ===== rtl/core/cwfc_pkg.sv =====
// Shared types, constants and helpers for the Caesar word frequency counter.
package cwfc_pkg;

  localparam int unsigned DefaultEntries   = 1024;
  localparam int unsigned DefaultWordBytes = 64;
  localparam int unsigned CountWidth       = 32;
  localparam logic [4:0]  ShiftReset       = 5'd3;
  localparam logic [4:0]  Alphabet         = 5'd26;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_SKIPPED  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_FULL     = 2'd3
  } word_status_t;

  typedef struct packed {
    logic         latch_in;
    logic         tok_step;
    logic         tok_clr;
    logic         clr_i;
    logic         inc_i;
    logic         clr_j;
    logic         inc_j;
    logic         meta_rd;
    logic         text_rd;
    logic         copy_rd;
    logic         copy_wr;
    logic         hit_wr;
    logic         new_wr;
    logic         res_word;
    word_status_t res_status;
    logic         load_out;
    logic         buf_end;
  } cmd_t;

  typedef struct packed {
    logic is_delim;
    logic is_open;
    logic last;
    logic skipped;
    logic overlong;
    logic i_end;
    logic len_eq;
    logic j_end;
    logic byte_eq;
    logic full;
  } status_t;

  function automatic logic is_delim(input logic [7:0] c);
    return c == 8'h20 || c == 8'h2E || c == 8'h2C || c == 8'h3A ||
           c == 8'h3B || c == 8'h3F || c == 8'h0A || c == 8'h00;
  endfunction

  function automatic logic [7:0] decipher(input logic [7:0] c, input logic [4:0] shift);
    logic [4:0] s;
    logic [7:0] base;
    logic [5:0] t;
    logic       letter;
    s      = (shift >= Alphabet) ? shift - Alphabet : shift;
    letter = 1'b1;
    base   = 8'h61;
    if (c >= 8'h61 && c <= 8'h7A) begin
      base = 8'h61;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      base = 8'h41;
    end else begin
      letter = 1'b0;
    end
    t = 6'(c - base) + 6'(Alphabet) - 6'(s);
    if (t >= 6'(Alphabet)) begin
      t = t - 6'(Alphabet);
    end
    return letter ? base + 8'(t) : c;
  endfunction

endpackage

// ===== rtl/core/caesar_word_frequency_counter.sv =====
// A byte that closes no word passes through the step and finish states to the output register.
// A counted word adds the lookup walk over simple dual-port RAMs: a length check per stored
// entry, a compare per byte on a length match, and a copy per byte for a new word.
// One byte is in work at a time; the next is taken once its result is in the output register.
// Reset is synchronous: the table and the open word are empty and the shift returns to 3.
// Table memories are never cleared; a fill count marks which entries hold words.
module caesar_word_frequency_counter #(
  parameter int unsigned ENTRIES    = cwfc_pkg::DefaultEntries,
  parameter int unsigned WORD_BYTES = cwfc_pkg::DefaultWordBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  plain_byte,
  output logic        word_done,
  output logic [1:0]  word_status,
  output logic [9:0]  entry_index,
  output logic [31:0] word_count,
  output logic        new_entry
);

  cwfc_pkg::cmd_t    cmd;
  cwfc_pkg::status_t status;
  logic [4:0]        shift_amount;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(shift_amount) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= cwfc_pkg::ShiftReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      shift_amount <= pwdata[4:0];
    end
  end

  cwfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cwfc_datapath #(.ENTRIES(ENTRIES), .WORD_BYTES(WORD_BYTES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .shift_amount   (shift_amount),
    .data_byte      (data_byte),
    .last_of_buffer (last_of_buffer),
    .plain_byte     (plain_byte),
    .word_done      (word_done),
    .word_status    (word_status),
    .entry_index    (entry_index),
    .word_count     (word_count),
    .new_entry      (new_entry)
  );

endmodule

// ===== rtl/core/cwfc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cwfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cwfc_datapath.sv =====
// Datapath: token store, word table, counters, result and output registers.
module cwfc_datapath #(
  parameter int unsigned ENTRIES    = cwfc_pkg::DefaultEntries,
  parameter int unsigned WORD_BYTES = cwfc_pkg::DefaultWordBytes
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cwfc_pkg::cmd_t        cmd,
  output cwfc_pkg::status_t     status,
  input  logic [4:0]            shift_amount,
  input  logic [7:0]            data_byte,
  input  logic                  last_of_buffer,
  output logic [7:0]            plain_byte,
  output logic                  word_done,
  output logic [1:0]            word_status,
  output logic [9:0]            entry_index,
  output logic [31:0]           word_count,
  output logic                  new_entry
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned JW = $clog2(WORD_BYTES);
  localparam int unsigned LW = $clog2(WORD_BYTES + 1);
  localparam int unsigned MW = LW + cwfc_pkg::CountWidth;

  logic [7:0]  c_reg;
  logic        last_reg;
  logic [CW-1:0] i, used;
  logic [LW-1:0] j, tok_len;
  logic        skipped, overlong;
  logic        r_done, r_new;
  cwfc_pkg::word_status_t r_status;
  logic [CW-1:0] r_idx;
  logic [31:0] r_count;
  logic [7:0]  p, lower;
  logic        tok_room;
  logic [7:0]  text_q, tok_q;
  logic [MW-1:0] meta_q, meta_wdata;
  logic [31:0] cnt_sat;
  logic [31:0] idx_wide;

  assign p        = cwfc_pkg::decipher(c_reg, shift_amount);
  assign lower    = (p >= 8'h41 && p <= 8'h5A) ? p + 8'h20 : p;
  assign tok_room = tok_len < LW'(WORD_BYTES);
  assign cnt_sat  = (meta_q[31:0] == 32'hFFFF_FFFF) ? meta_q[31:0] : meta_q[31:0] + 32'd1;
  assign meta_wdata = cmd.hit_wr ? {tok_len, cnt_sat} : {tok_len, 32'd1};

  cwfc_ram #(.WIDTH(8), .DEPTH(ENTRIES << JW)) u_text (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr ({used[IW-1:0], j[JW-1:0]}),
    .wdata (tok_q),
    .re    (cmd.text_rd),
    .raddr ({i[IW-1:0], j[JW-1:0]}),
    .rdata (text_q)
  );

  cwfc_ram #(.WIDTH(8), .DEPTH(WORD_BYTES)) u_token (
    .clk   (clk),
    .we    (cmd.tok_step && tok_room),
    .waddr (tok_len[JW-1:0]),
    .wdata (lower),
    .re    (cmd.text_rd || cmd.copy_rd),
    .raddr (j[JW-1:0]),
    .rdata (tok_q)
  );

  cwfc_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
    .clk   (clk),
    .we    (cmd.hit_wr || cmd.new_wr),
    .waddr (cmd.hit_wr ? i[IW-1:0] : used[IW-1:0]),
    .wdata (meta_wdata),
    .re    (cmd.meta_rd),
    .raddr (i[IW-1:0]),
    .rdata (meta_q)
  );

  always_comb begin
    status.is_delim = cwfc_pkg::is_delim(p);
    status.is_open  = (tok_len != '0) || skipped || overlong;
    status.last     = last_reg;
    status.skipped  = skipped;
    status.overlong = overlong;
    status.i_end    = i == used;
    status.len_eq   = meta_q[MW-1:32] == tok_len;
    status.j_end    = j == tok_len;
    status.byte_eq  = text_q == tok_q;
    status.full     = used == CW'(ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      tok_len  <= '0;
      skipped  <= 1'b0;
      overlong <= 1'b0;
    end else begin
      if (cmd.tok_step) begin
        if (!status.is_open && p >= 8'h30 && p <= 8'h39) begin
          skipped <= 1'b1;
        end
        if (tok_room) begin
          tok_len <= tok_len + LW'(1);
        end else begin
          overlong <= 1'b1;
        end
      end
      if (cmd.new_wr) begin
        used <= used + CW'(1);
      end
      if (cmd.tok_clr || cmd.buf_end) begin
        tok_len  <= '0;
        skipped  <= 1'b0;
        overlong <= 1'b0;
      end
      if (cmd.buf_end) begin
        used <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      c_reg    <= data_byte;
      last_reg <= last_of_buffer;
      r_done   <= 1'b0;
      r_status <= cwfc_pkg::ST_COUNTED;
      r_idx    <= '0;
      r_count  <= '0;
      r_new    <= 1'b0;
    end
    if (cmd.clr_i) begin
      i <= '0;
    end else if (cmd.inc_i) begin
      i <= i + CW'(1);
    end
    if (cmd.clr_j) begin
      j <= '0;
    end else if (cmd.inc_j) begin
      j <= j + LW'(1);
    end
    if (cmd.res_word) begin
      r_done   <= 1'b1;
      r_status <= cmd.res_status;
    end
    if (cmd.hit_wr) begin
      r_done  <= 1'b1;
      r_idx   <= i;
      r_count <= cnt_sat;
    end
    if (cmd.new_wr) begin
      r_done  <= 1'b1;
      r_idx   <= used;
      r_count <= 32'd1;
      r_new   <= 1'b1;
    end
    if (cmd.load_out) begin
      plain_byte  <= p;
      word_done   <= r_done;
      word_status <= r_status;
      entry_index <= idx_wide[9:0];
      word_count  <= r_count;
      new_entry   <= r_new;
    end
  end

  assign idx_wide = 32'(r_idx);

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= CW'(ENTRIES))
    else $error("table fill count beyond capacity");
  a_tok_bound: assert property (@(posedge clk) disable iff (rst)
    tok_len <= LW'(WORD_BYTES))
    else $error("token length beyond store");
  a_no_new_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.new_wr |-> !status.full)
    else $error("new entry written into a full table");

endmodule

// ===== rtl/core/cwfc_ctrl.sv =====
// Controller: sequences each byte, the table lookup walk and the output handshake.
module cwfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cwfc_pkg::status_t status,
  output cwfc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_CLOSE, S_M_RD, S_M_CHK, S_B_RD, S_B_CHK,
    S_HIT, S_MISS, S_C_RD, S_C_WR, S_NEW_WR, S_FINISH
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_STEP;
        end
      end
      S_STEP: begin
        if (status.is_delim) begin
          state_next = status.is_open ? S_CLOSE : S_FINISH;
        end else begin
          cmd.tok_step = 1'b1;
          state_next   = status.last ? S_CLOSE : S_FINISH;
        end
      end
      S_CLOSE: begin
        if (status.skipped) begin
          cmd.res_word   = 1'b1;
          cmd.res_status = cwfc_pkg::ST_SKIPPED;
          cmd.tok_clr    = 1'b1;
          state_next     = S_FINISH;
        end else if (status.overlong) begin
          cmd.res_word   = 1'b1;
          cmd.res_status = cwfc_pkg::ST_TOO_LONG;
          cmd.tok_clr    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.clr_i  = 1'b1;
          state_next = S_M_RD;
        end
      end
      S_M_RD: begin
        if (status.i_end) begin
          state_next = S_MISS;
        end else begin
          cmd.meta_rd = 1'b1;
          state_next  = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (status.len_eq) begin
          cmd.clr_j  = 1'b1;
          state_next = S_B_RD;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_M_RD;
        end
      end
      S_B_RD: begin
        if (status.j_end) begin
          state_next = S_HIT;
        end else begin
          cmd.text_rd = 1'b1;
          state_next  = S_B_CHK;
        end
      end
      S_B_CHK: begin
        if (status.byte_eq) begin
          cmd.inc_j  = 1'b1;
          state_next = S_B_RD;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_M_RD;
        end
      end
      S_HIT: begin
        cmd.hit_wr  = 1'b1;
        cmd.tok_clr = 1'b1;
        state_next  = S_FINISH;
      end
      S_MISS: begin
        if (status.full) begin
          cmd.res_word   = 1'b1;
          cmd.res_status = cwfc_pkg::ST_FULL;
          cmd.tok_clr    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.clr_j  = 1'b1;
          state_next = S_C_RD;
        end
      end
      S_C_RD: begin
        if (status.j_end) begin
          state_next = S_NEW_WR;
        end else begin
          cmd.copy_rd = 1'b1;
          state_next  = S_C_WR;
        end
      end
      S_C_WR: begin
        cmd.copy_wr = 1'b1;
        cmd.inc_j   = 1'b1;
        state_next  = S_C_RD;
      end
      S_NEW_WR: begin
        cmd.new_wr  = 1'b1;
        cmd.tok_clr = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.buf_end  = status.last;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending word overwritten");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule
